### rtl/gxp_pkg.sv
// ----------------------------------------------------------------------------
// gxp_pkg
// Shared constants, the control word type and the microcode table of the
// grid exit path counter.
// ----------------------------------------------------------------------------
package gxp_pkg;

    localparam int GXP_MAX_DIM   = 64;
    localparam int GXP_MAX_MOVES = 64;

    localparam int          CNT_W    = 30;
    localparam logic [29:0] EXIT_MOD = 30'd1000000007;

    localparam int START_W = 6;
    localparam int MOVES_W = 7;
    localparam int CFG_W   = 7;

    localparam logic CFG_GRID_ROWS = 1'b0;
    localparam logic CFG_GRID_COLS = 1'b1;

    localparam int STEP_W = 4;

    localparam logic [STEP_W-1:0] ST_IDLE   = 4'd0;
    localparam logic [STEP_W-1:0] ST_CHECK  = 4'd1;
    localparam logic [STEP_W-1:0] ST_RD_V   = 4'd2;
    localparam logic [STEP_W-1:0] ST_RD_H   = 4'd3;
    localparam logic [STEP_W-1:0] ST_SUM_H  = 4'd4;
    localparam logic [STEP_W-1:0] ST_WRITE  = 4'd5;
    localparam logic [STEP_W-1:0] ST_LAYER  = 4'd6;
    localparam logic [STEP_W-1:0] ST_RD_RES = 4'd7;
    localparam logic [STEP_W-1:0] ST_CAP    = 4'd8;
    localparam logic [STEP_W-1:0] ST_RESULT = 4'd9;

    localparam int JC_W = 3;

    localparam logic [JC_W-1:0] JC_NONE       = 3'd0;
    localparam logic [JC_W-1:0] JC_ALWAYS     = 3'd1;
    localparam logic [JC_W-1:0] JC_NO_ACCEPT  = 3'd2;
    localparam logic [JC_W-1:0] JC_TRIVIAL    = 3'd3;
    localparam logic [JC_W-1:0] JC_CELL_MORE  = 3'd4;
    localparam logic [JC_W-1:0] JC_LAYER_MORE = 3'd5;
    localparam logic [JC_W-1:0] JC_OUT_BUSY   = 3'd6;

    typedef struct packed {
        logic [JC_W-1:0]   jcond;
        logic [STEP_W-1:0] target;
        logic              accept;
        logic              check;
        logic              rd_v;
        logic              rd_h;
        logic              sum_v;
        logic              sum_h;
        logic              write;
        logic              adv_layer;
        logic              rd_res;
        logic              cap_res;
        logic              load_out;
    } ctrl_t;

    typedef struct packed {
        logic accepted;
        logic trivial;
        logic cell_more;
        logic layer_more;
        logic out_busy;
    } cond_t;

    function automatic ctrl_t ucode(input logic [STEP_W-1:0] step);
        ctrl_t w;
        w = '0;
        case (step)
            ST_IDLE:
            begin
                w.accept = 1'b1;
                w.jcond  = JC_NO_ACCEPT;
                w.target = ST_IDLE;
            end
            ST_CHECK:
            begin
                w.check  = 1'b1;
                w.jcond  = JC_TRIVIAL;
                w.target = ST_RESULT;
            end
            ST_RD_V:
            begin
                w.rd_v = 1'b1;
            end
            ST_RD_H:
            begin
                w.rd_h  = 1'b1;
                w.sum_v = 1'b1;
            end
            ST_SUM_H:
            begin
                w.sum_h = 1'b1;
            end
            ST_WRITE:
            begin
                w.write  = 1'b1;
                w.jcond  = JC_CELL_MORE;
                w.target = ST_RD_V;
            end
            ST_LAYER:
            begin
                w.adv_layer = 1'b1;
                w.jcond     = JC_LAYER_MORE;
                w.target    = ST_RD_V;
            end
            ST_RD_RES:
            begin
                w.rd_res = 1'b1;
            end
            ST_CAP:
            begin
                w.cap_res = 1'b1;
            end
            ST_RESULT:
            begin
                w.load_out = 1'b1;
                w.jcond    = JC_OUT_BUSY;
                w.target   = ST_RESULT;
            end
            default:
            begin
                w.jcond  = JC_ALWAYS;
                w.target = ST_IDLE;
            end
        endcase
        return w;
    endfunction

    // Sum of two residues (or a residue and one) brought back below the modulus.
    function automatic logic [CNT_W-1:0] mod_add(input logic [CNT_W-1:0] a,
                                                 input logic [CNT_W-1:0] b);
        logic [CNT_W:0] s;
        logic [CNT_W:0] d;
        s = {1'b0, a} + {1'b0, b};
        d = s - {1'b0, EXIT_MOD};
        return (s >= {1'b0, EXIT_MOD}) ? d[CNT_W-1:0] : s[CNT_W-1:0];
    endfunction

endpackage

### rtl/grid_exit_path_counter.sv
// ----------------------------------------------------------------------------
// grid_exit_path_counter
// Counts the walks from a start cell that leave the grid within a move
// budget, modulo 1000000007, by a layer-by-layer sweep over two RAM banks.
// ----------------------------------------------------------------------------
// A start outside the grid or a zero budget jumps from the check step to the result
// step; otherwise every layer sweeps all cells before the start cell is read.
// Each cell update takes 4 steps of the sequencer, set by the two read ports.
// One query is worked at a time; after a result is loaded, a default step leads back
// to idle, where a new word is taken while that result waits. Reset sets both grid
// dimensions to 1; the RAM is not cleared and needs no clearing pass.
// ----------------------------------------------------------------------------
module grid_exit_path_counter #(
    parameter int MAX_DIM   = gxp_pkg::GXP_MAX_DIM,
    parameter int MAX_MOVES = gxp_pkg::GXP_MAX_MOVES
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        cfg_wr_en,
    input  logic        cfg_index,
    input  logic [6:0]  cfg_data,
    input  logic        s_tvalid,
    output logic        s_tready,
    // start_row [5:0], start_col [11:6], max_moves [18:12], zero [23:19]
    input  logic [23:0] s_tdata,
    output logic        m_tvalid,
    input  logic        m_tready,
    // path_count [29:0], zero [31:30]
    output logic [31:0] m_tdata
);

    import gxp_pkg::*;

    localparam int DIM_W   = (MAX_DIM > 1) ? $clog2(MAX_DIM) : 1;
    localparam int DIMC_W  = $clog2(MAX_DIM + 1);
    localparam int MV_W    = $clog2(MAX_MOVES + 1);
    localparam int RA_W    = 1 + 2 * DIM_W;
    localparam int DEPTH   = 1 << RA_W;
    localparam int SCMP_W  = (DIMC_W > START_W) ? DIMC_W : START_W;
    localparam int CCMP_W  = (DIMC_W > CFG_W) ? DIMC_W : CFG_W;
    localparam int MCMP_W  = (MV_W > MOVES_W) ? MV_W : MOVES_W;

    ctrl_t ctrl;
    cond_t cond;

    logic [DIMC_W-1:0]  rows_reg, rows_next;
    logic [DIMC_W-1:0]  cols_reg, cols_next;
    logic [CCMP_W-1:0]  cfg_ext;
    logic [DIMC_W-1:0]  cfg_clamped;

    logic [START_W-1:0] srow_reg, scol_reg;
    logic [MV_W-1:0]    moves_reg;
    logic [MCMP_W-1:0]  moves_ext;
    logic [MV_W-1:0]    moves_clamped;

    logic [DIM_W-1:0]   row_reg, col_reg;
    logic [MV_W-1:0]    t_reg;
    logic [DIMC_W-1:0]  row_inc, col_inc;
    logic               row_end, col_end;
    logic               first_layer;
    logic               out_of_grid;

    logic               va_reg, vb_reg;
    logic [CNT_W-1:0]   pair_v_reg;
    logic [CNT_W-1:0]   pair_h_reg;
    logic [CNT_W-1:0]   val_a, val_b, pair_sum, total;
    logic [CNT_W-1:0]   result_reg;

    logic               m_tvalid_reg;
    logic [CNT_W-1:0]   path_count_reg;

    logic               accepted;
    logic               wr_en;
    logic [RA_W-1:0]    wr_addr, rd_addr_a, rd_addr_b;
    logic [CNT_W-1:0]   rd_data_a, rd_data_b;

    gxp_seq u_seq (
        .clk   (clk),
        .rst_n (rst_n),
        .cond  (cond),
        .ctrl  (ctrl)
    );

    gxp_ram #(
        .WIDTH (CNT_W),
        .DEPTH (DEPTH)
    ) u_ram (
        .clk       (clk),
        .wr_en     (wr_en),
        .wr_addr   (wr_addr),
        .wr_data   (total),
        .rd_addr_a (rd_addr_a),
        .rd_data_a (rd_data_a),
        .rd_addr_b (rd_addr_b),
        .rd_data_b (rd_data_b)
    );

    assign s_tready = ctrl.accept;
    assign accepted = s_tvalid && s_tready;
    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = {2'b00, path_count_reg};

    always_comb
    begin
        cfg_ext     = CCMP_W'(cfg_data);
        cfg_clamped = (cfg_ext > CCMP_W'(MAX_DIM)) ? DIMC_W'(MAX_DIM) : DIMC_W'(cfg_ext);
        rows_next   = rows_reg;
        cols_next   = cols_reg;
        if (cfg_wr_en && (cfg_index == CFG_GRID_ROWS))
        begin
            rows_next = cfg_clamped;
        end
        if (cfg_wr_en && (cfg_index == CFG_GRID_COLS))
        begin
            cols_next = cfg_clamped;
        end
    end

    always_comb
    begin
        moves_ext     = MCMP_W'(s_tdata[18:12]);
        moves_clamped = (moves_ext > MCMP_W'(MAX_MOVES)) ? MV_W'(MAX_MOVES) : MV_W'(moves_ext);

        out_of_grid = (SCMP_W'(srow_reg) >= SCMP_W'(rows_reg))
                   || (SCMP_W'(scol_reg) >= SCMP_W'(cols_reg));

        row_inc     = DIMC_W'(row_reg) + DIMC_W'(1);
        col_inc     = DIMC_W'(col_reg) + DIMC_W'(1);
        row_end     = (row_inc == rows_reg);
        col_end     = (col_inc == cols_reg);
        first_layer = (t_reg == MV_W'(1));

        cond.accepted   = accepted;
        cond.trivial    = out_of_grid || (moves_reg == '0);
        cond.cell_more  = !(row_end && col_end);
        cond.layer_more = (t_reg != moves_reg);
        cond.out_busy   = m_tvalid_reg && !m_tready;

        // Neighbors off the grid count one exit; the first layer reads as zero.
        val_a    = !va_reg ? CNT_W'(1) : (first_layer ? '0 : rd_data_a);
        val_b    = !vb_reg ? CNT_W'(1) : (first_layer ? '0 : rd_data_b);
        pair_sum = mod_add(val_a, val_b);
        total    = mod_add(pair_v_reg, pair_h_reg);

        wr_en   = ctrl.write;
        wr_addr = {t_reg[0], row_reg, col_reg};

        if (ctrl.rd_res)
        begin
            rd_addr_a = {t_reg[0], DIM_W'(srow_reg), DIM_W'(scol_reg)};
            rd_addr_b = rd_addr_a;
        end
        else if (ctrl.rd_h)
        begin
            rd_addr_a = {~t_reg[0], row_reg, col_reg - DIM_W'(1)};
            rd_addr_b = {~t_reg[0], row_reg, col_inc[DIM_W-1:0]};
        end
        else
        begin
            rd_addr_a = {~t_reg[0], row_reg - DIM_W'(1), col_reg};
            rd_addr_b = {~t_reg[0], row_inc[DIM_W-1:0], col_reg};
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rows_reg     <= DIMC_W'(1);
            cols_reg     <= DIMC_W'(1);
            m_tvalid_reg <= 1'b0;
            moves_reg    <= '0;
            t_reg        <= '0;
            row_reg      <= '0;
            col_reg      <= '0;
        end
        else
        begin
            rows_reg <= rows_next;
            cols_reg <= cols_next;

            if (ctrl.load_out && !cond.out_busy)
            begin
                m_tvalid_reg <= 1'b1;
            end
            else if (m_tready)
            begin
                m_tvalid_reg <= 1'b0;
            end

            if (accepted)
            begin
                moves_reg <= moves_clamped;
                t_reg     <= MV_W'(1);
                row_reg   <= '0;
                col_reg   <= '0;
            end

            if (ctrl.write)
            begin
                if (col_end)
                begin
                    col_reg <= '0;
                    row_reg <= row_end ? '0 : row_inc[DIM_W-1:0];
                end
                else
                begin
                    col_reg <= col_inc[DIM_W-1:0];
                end
            end

            if (ctrl.adv_layer && cond.layer_more)
            begin
                t_reg <= t_reg + MV_W'(1);
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (accepted)
        begin
            srow_reg <= s_tdata[5:0];
            scol_reg <= s_tdata[11:6];
        end
        if (ctrl.rd_v)
        begin
            va_reg <= (row_reg != '0);
            vb_reg <= (row_inc < rows_reg);
        end
        if (ctrl.rd_h)
        begin
            va_reg <= (col_reg != '0);
            vb_reg <= (col_inc < cols_reg);
        end
        if (ctrl.sum_v)
        begin
            pair_v_reg <= pair_sum;
        end
        if (ctrl.sum_h)
        begin
            pair_h_reg <= pair_sum;
        end
        if (ctrl.check)
        begin
            result_reg <= out_of_grid ? CNT_W'(1) : '0;
        end
        if (ctrl.cap_res)
        begin
            result_reg <= rd_data_a;
        end
        if (ctrl.load_out && !cond.out_busy)
        begin
            path_count_reg <= result_reg;
        end
    end

endmodule

### rtl/gxp_ram.sv
// ----------------------------------------------------------------------------
// gxp_ram
// Generic RAM with one write port and two registered read ports.
// ----------------------------------------------------------------------------
module gxp_ram #(
    parameter int WIDTH = 30,
    parameter int DEPTH = 8192
) (
    input  logic                     clk,
    input  logic                     wr_en,
    input  logic [$clog2(DEPTH)-1:0] wr_addr,
    input  logic [WIDTH-1:0]         wr_data,
    input  logic [$clog2(DEPTH)-1:0] rd_addr_a,
    output logic [WIDTH-1:0]         rd_data_a,
    input  logic [$clog2(DEPTH)-1:0] rd_addr_b,
    output logic [WIDTH-1:0]         rd_data_b
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        rd_data_a <= mem[rd_addr_a];
        rd_data_b <= mem[rd_addr_b];
    end

endmodule

### rtl/gxp_seq.sv
// ----------------------------------------------------------------------------
// gxp_seq
// Microcode sequencer: step counter, control store and conditional jumps.
// ----------------------------------------------------------------------------
module gxp_seq (
    input  logic           clk,
    input  logic           rst_n,
    input  gxp_pkg::cond_t cond,
    output gxp_pkg::ctrl_t ctrl
);

    import gxp_pkg::*;

    logic [STEP_W-1:0] step_reg;
    logic [STEP_W-1:0] step_next;
    logic              taken;

    assign ctrl = ucode(step_reg);

    always_comb
    begin
        case (ctrl.jcond)
            JC_NONE:       taken = 1'b0;
            JC_ALWAYS:     taken = 1'b1;
            JC_NO_ACCEPT:  taken = !cond.accepted;
            JC_TRIVIAL:    taken = cond.trivial;
            JC_CELL_MORE:  taken = cond.cell_more;
            JC_LAYER_MORE: taken = cond.layer_more;
            JC_OUT_BUSY:   taken = cond.out_busy;
            default:       taken = 1'b1;
        endcase
        step_next = taken ? ctrl.target : step_reg + STEP_W'(1);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            step_reg <= ST_IDLE;
        end
        else
        begin
            step_reg <= step_next;
        end
    end

endmodule
